FILE: hw/rtl/pcm_frame_level_meter_defines.svh
// Assertion macros for the frame level meter checker.
// Depends on nothing; included by the checker file only.
`ifndef PCM_FRAME_LEVEL_METER_DEFINES_SVH
`define PCM_FRAME_LEVEL_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define PFL_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PFL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pfl_pkg.sv
// Shared types and constants of the PCM frame level meter.
// Used by pfl_apb, the top level and the checker; depends on nothing.
package pfl_pkg;

    localparam int unsigned MAX_FRAME_DEF = 4096;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PEAK_W   = 16;
    localparam int unsigned SQ_W     = 31;
    localparam int unsigned MEAN_W   = 48;
    localparam int unsigned ROOT_W   = 24;
    localparam int unsigned MIX_W    = 27;
    localparam int unsigned GAIN_W   = 8;
    localparam int unsigned PROD_W   = MIX_W + GAIN_W;
    localparam int unsigned LEVEL_W  = 7;
    localparam int unsigned FRAC_SHIFT  = 16;
    localparam int unsigned SCALE_SHIFT = 23;
    localparam int unsigned RAW_LVL_W   = PROD_W - SCALE_SHIFT;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 7'd100;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 8'd18;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_MIX,
        ST_MUL,
        ST_SCALE
    } t_state;

endpackage

FILE: hw/rtl/pfl_sub.sv
// Shared subtract and compare unit of the PCM frame level meter.
// Serves both the divider and the square root steps; depends on nothing.
module pfl_sub #(
    parameter int unsigned WIDTH = 27
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_diff,
    output logic             o_borrow
);

    logic [WIDTH:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[WIDTH-1:0];
    assign o_borrow = w_full[WIDTH];

endmodule

FILE: hw/rtl/pfl_apb.sv
// Configuration register port of the PCM frame level meter.
// Holds the display gain; depends on pfl_pkg.
module pfl_apb
    import pfl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [GAIN_W-1:0]     o_gain
);

    logic [GAIN_W-1:0]    r_gain;
    logic [GAIN_W-1:0]    n_gain;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign pready = 1'b1;
    assign o_gain = r_gain;

    always_comb begin
        n_gain = r_gain;
        if (psel && penable && pwrite && (w_idx == REG_GAIN)) begin
            n_gain = pwdata[GAIN_W-1:0];
        end
    end

    always_comb begin
        if (w_idx == REG_GAIN) begin
            prdata = APB_DATA_W'(r_gain);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else begin
            r_gain <= n_gain;
        end
    end

endmodule

FILE: hw/rtl/pcm_frame_level_meter.sv
// Top level of the PCM frame level meter: sequencer, frame accumulators and datapath.
// Depends on pfl_pkg, pfl_sub and pfl_apb.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_sample, i_last_sample
//   output    out        o_out_valid / i_out_stall  o_level
//   config    in         psel, penable, pready      paddr, pwdata, prdata
//
// A sample that is not the frame's last goes through square, then accumulate.
// The last sample then runs the shared subtractor: one quotient bit of the mean
// per cycle, then one root bit per cycle.
// Synchronous reset clears the sequencer, the frame sums and the output valid flag.
// A held output stalls only the end of the next frame; samples keep flowing meanwhile.
module pcm_frame_level_meter
    import pfl_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [LEVEL_W-1:0]         o_level,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int unsigned CW     = $clog2(MAX_FRAME + 1);
    localparam int unsigned SW     = SQ_W + CW;
    localparam int unsigned NW     = SW + FRAC_SHIFT;
    localparam int unsigned UW     = (CW + 1 > ROOT_W + 3) ? CW + 1 : ROOT_W + 3;
    localparam int unsigned STEPN  = (NW > ROOT_W) ? NW : ROOT_W;
    localparam int unsigned STEP_W = $clog2(STEPN);

    t_state r_state, n_state;

    logic [PEAK_W-1:0]   r_mag, n_mag;
    logic                r_last, n_last;
    logic                r_take, n_take;
    logic [SQ_W-1:0]     r_sq, n_sq;
    logic [PEAK_W-1:0]   r_peak, n_peak;
    logic [SW-1:0]       r_sum, n_sum;
    logic [CW-1:0]       r_count, n_count;
    logic [NW-1:0]       r_num, n_num;
    logic [CW-1:0]       r_rem, n_rem;
    logic [MEAN_W-1:0]   r_rad, n_rad;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [UW-1:0]       r_srem, n_srem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [MIX_W-1:0]    r_mixed, n_mixed;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic                r_out_valid, n_out_valid;
    logic [LEVEL_W-1:0]  r_level, n_level;

    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_sel_sqrt;
    logic [PEAK_W-1:0]   w_mag;
    logic [CW:0]         w_dpart;
    logic [UW-1:0]       w_spart;
    logic [UW-1:0]       w_ua, w_ub, w_diff;
    logic                w_borrow;
    logic [RAW_LVL_W-1:0] w_raw_lvl;
    logic [GAIN_W-1:0]   w_gain;

    pfl_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gain  (w_gain)
    );

    pfl_sub #(
        .WIDTH (UW)
    ) u_sub (
        .i_a      (w_ua),
        .i_b      (w_ub),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign w_mag     = i_sample[SAMPLE_W-1] ? PEAK_W'(~i_sample + 1'b1) : PEAK_W'(i_sample);
    assign w_dpart   = {r_rem, r_num[NW-1]};
    assign w_spart   = {r_srem[UW-3:0], r_rad[MEAN_W-1 -: 2]};
    assign w_ua      = w_sel_sqrt ? w_spart : UW'(w_dpart);
    assign w_ub      = w_sel_sqrt ? UW'({r_root, 2'b01}) : UW'(r_count);
    assign w_raw_lvl = r_prod[PROD_W-1:SCALE_SHIFT];

    assign o_out_valid = r_out_valid;
    assign o_level     = r_level;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: n_state = ST_ACCUM;
            ST_ACCUM: begin
                n_state = r_last ? ST_DIV_INIT : ST_IDLE;
            end
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == '0) begin
                    n_state = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT: n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_step == '0) begin
                    n_state = ST_MIX;
                end
            end
            ST_MIX: n_state = ST_MUL;
            ST_MUL: n_state = ST_SCALE;
            ST_SCALE: begin
                if (!r_out_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_sel_sqrt = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_SQRT: w_sel_sqrt = 1'b1;
            default: begin
                o_in_stall = 1'b1;
                w_sel_sqrt = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mag       = r_mag;
        n_last      = r_last;
        n_take      = r_take;
        n_sq        = r_sq;
        n_peak      = r_peak;
        n_sum       = r_sum;
        n_count     = r_count;
        n_num       = r_num;
        n_rem       = r_rem;
        n_rad       = r_rad;
        n_root      = r_root;
        n_srem      = r_srem;
        n_step      = r_step;
        n_mixed     = r_mixed;
        n_prod      = r_prod;
        n_out_valid = w_out_acc ? 1'b0 : r_out_valid;
        n_level     = r_level;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_mag  = w_mag;
                    n_last = i_last_sample;
                    n_take = (r_count < CW'(MAX_FRAME));
                end
            end
            ST_SQUARE: begin
                n_sq = SQ_W'(r_mag * r_mag);
                if (r_take && (r_mag > r_peak)) begin
                    n_peak = r_mag;
                end
            end
            ST_ACCUM: begin
                if (r_take) begin
                    n_sum   = r_sum + SW'(r_sq);
                    n_count = r_count + 1'b1;
                end
            end
            ST_DIV_INIT: begin
                n_num  = {r_sum, FRAC_SHIFT'(0)};
                n_rem  = '0;
                n_step = STEP_W'(NW - 1);
            end
            ST_DIV: begin
                n_rem  = w_borrow ? w_dpart[CW-1:0] : w_diff[CW-1:0];
                n_num  = {r_num[NW-2:0], !w_borrow};
                n_step = r_step - 1'b1;
            end
            ST_SQRT_INIT: begin
                n_rad  = MEAN_W'(r_num);
                n_root = '0;
                n_srem = '0;
                n_step = STEP_W'(ROOT_W - 1);
            end
            ST_SQRT: begin
                n_srem = w_borrow ? w_spart : w_diff;
                n_root = {r_root[ROOT_W-2:0], !w_borrow};
                n_rad  = {r_rad[MEAN_W-3:0], 2'b00};
                n_step = r_step - 1'b1;
            end
            ST_MIX: begin
                n_mixed = (MIX_W'(r_root) << 3) - MIX_W'(r_root)
                        + (MIX_W'(r_peak) << 9) + (MIX_W'(r_peak) << 8);
            end
            ST_MUL: begin
                n_prod = PROD_W'(r_mixed * w_gain);
            end
            ST_SCALE: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_level     = (w_raw_lvl > RAW_LVL_W'(LEVEL_MAX)) ?
                                  LEVEL_MAX : LEVEL_W'(w_raw_lvl);
                    n_peak      = '0;
                    n_sum       = '0;
                    n_count     = '0;
                end
            end
            default: n_step = r_step;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_peak      <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_peak      <= n_peak;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_last  <= n_last;
        r_take  <= n_take;
        r_sq    <= n_sq;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_rad   <= n_rad;
        r_root  <= n_root;
        r_srem  <= n_srem;
        r_mixed <= n_mixed;
        r_prod  <= n_prod;
        r_level <= n_level;
    end

endmodule

FILE: hw/rtl/pfl_checker.sv
// Port-level checker of the PCM frame level meter, bound to the top level.
// Depends on pfl_pkg and pcm_frame_level_meter_defines.svh.
`include "pcm_frame_level_meter_defines.svh"

module pfl_checker
    import pfl_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       i_last_sample,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [LEVEL_W-1:0]         o_level
);

    `PFL_ASSERT_NOW(a_level_range, i_clk, i_rst_n, o_out_valid, o_level <= LEVEL_MAX, "level above full scale")
    `PFL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_level), "stalled result transfer changed")
    `PFL_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_last_sample, o_in_stall, "input taken while frame end in progress")
    `PFL_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result appeared without frame end work")

endmodule

bind pcm_frame_level_meter pfl_checker u_pfl_checker (.*);
